[src/otsu_threshold_finder_defines.svh]
// Assertion macros for the Otsu threshold finder.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef OTSU_THRESHOLD_FINDER_DEFINES_SVH
`define OTSU_THRESHOLD_FINDER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define OTSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otsu: same-cycle check failed");

// Next-cycle implication
`define OTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otsu: next-cycle check failed");

`else

`define OTSU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/otsu_pkg.sv]
package otsu_pkg;

    // Sizing
    localparam int unsigned MAX_SAMPLES = 1048576;
    localparam int unsigned NUM_BINS    = 256;
    localparam int unsigned BIN_W       = $clog2(NUM_BINS);
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W       = CNT_W + BIN_W;
    localparam int unsigned A_W         = CNT_W + SUM_W;   // total*sB, nB*sum
    localparam int unsigned D_W         = A_W;             // |a - b|
    localparam int unsigned D2_W        = 2 * D_W;         // d squared
    localparam int unsigned P_W         = 2 * CNT_W;       // nB*nF
    localparam int unsigned MC_W        = D2_W;            // multiplicand width
    localparam int unsigned MQ_W        = D_W;             // multiplier width
    localparam int unsigned PROD_W      = MC_W + MQ_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(NUM_BINS - 1);

    // Pixel channels
    localparam int unsigned PIX_W = 8;
    localparam int unsigned CHAN_W = 2;
    localparam logic [CHAN_W-1:0] CHAN_SEL_0 = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_SEL_1 = 2'd1;

    // Register port
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned REG_IDX_BIT = 2;
    localparam logic        REG_CHAN_SEL = 1'b0;

    typedef enum logic [2:0] {
        TS_CLEAR,
        TS_IDLE,
        TS_UPD,
        TS_SCAN,
        TS_EMIT
    } t_top_state;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_READ,
        SC_ACC,
        SC_MUL_A,
        SC_MUL_B,
        SC_MUL_P,
        SC_MUL_D2,
        SC_MUL_L,
        SC_MUL_R,
        SC_NEXT,
        SC_DONE
    } t_scan_state;

    // Scan side histogram request: read a bin and zero it in the same cycle
    typedef struct packed {
        logic             rd;
        logic [BIN_W-1:0] addr;
    } t_scan_mem;

    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] thr;
        logic [BIN_W-1:0] last_bin;
    } t_scan_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

[src/otsu_hist.sv]
module otsu_hist
    import otsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [BIN_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [BIN_W-1:0] i_wr_addr,
    input  logic [CNT_W-1:0] i_wr_data,
    output logic [CNT_W-1:0] o_rd_data
);

    logic [CNT_W-1:0] r_mem [NUM_BINS];
    logic [CNT_W-1:0] r_rd_data;

    // One write port, one registered read port; read returns the old value
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/otsu_mul.sv]
module otsu_mul
    import otsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MC_W-1:0]   i_mcand,
    input  logic [MQ_W-1:0]   i_mplier,
    output t_mul_stat         o_stat,
    output logic [PROD_W-1:0] o_prod
);

    logic              r_active;
    logic [PROD_W-1:0] r_m;
    logic [MQ_W-1:0]   r_q;
    logic [PROD_W-1:0] r_acc;
    logic              done;

    // Finished once every multiplier bit has been consumed
    assign done = r_active && (r_q == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (done) begin
            r_active <= 1'b0;
        end
    end

    // Shift-add, one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= PROD_W'(i_mcand);
            r_q   <= i_mplier;
            r_acc <= '0;
        end else if (r_active && (r_q != '0)) begin
            r_acc <= r_acc + (r_q[0] ? r_m : '0);
            r_m   <= r_m << 1;
            r_q   <= r_q >> 1;
        end
    end

    assign o_stat.busy = r_active;
    assign o_stat.done = done;
    assign o_prod      = r_acc;

endmodule

[src/otsu_scan.sv]
module otsu_scan
    import otsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_total,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [CNT_W-1:0] i_rd_data,
    output t_scan_mem        o_mem,
    output t_scan_stat       o_stat
);

    t_scan_state r_state, n_state;

    logic [BIN_W-1:0]  r_bin;
    logic [CNT_W-1:0]  r_nb;
    logic [SUM_W-1:0]  r_sb;
    logic [A_W-1:0]    r_a;
    logic [D_W-1:0]    r_d;
    logic [P_W-1:0]    r_p;
    logic [D2_W-1:0]   r_d2;
    logic [PROD_W-1:0] r_lhs;
    logic [D2_W-1:0]   r_best_d2;
    logic [P_W-1:0]    r_best_p;
    logic              r_have;
    logic [BIN_W-1:0]  r_thr;

    logic [CNT_W-1:0]  nb_new;
    logic [SUM_W-1:0]  sb_new;
    logic [A_W-1:0]    b_val;
    logic [D_W-1:0]    d_abs;

    logic              mul_start;
    logic [MC_W-1:0]   mul_mcand;
    logic [MQ_W-1:0]   mul_mplier;
    t_mul_stat         mul_stat;
    logic [PROD_W-1:0] mul_prod;

    otsu_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_stat   (mul_stat),
        .o_prod   (mul_prod)
    );

    // Running background count and value sum
    assign nb_new = r_nb + i_rd_data;
    assign sb_new = r_sb + (SUM_W'(r_bin) * SUM_W'(i_rd_data));

    // d = |total*sB - nB*sum|
    assign b_val = mul_prod[A_W-1:0];
    assign d_abs = (r_a >= b_val) ? (r_a - b_val) : (b_val - r_a);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SC_IDLE: begin
                if (i_start) n_state = SC_READ;
            end
            SC_READ: n_state = SC_ACC;
            SC_ACC: begin
                if (nb_new == '0) begin
                    n_state = SC_NEXT;
                end else if (nb_new >= i_total) begin
                    n_state = SC_DONE;
                end else begin
                    n_state = SC_MUL_A;
                end
            end
            SC_MUL_A: begin
                if (mul_stat.done) n_state = SC_MUL_B;
            end
            SC_MUL_B: begin
                if (mul_stat.done) n_state = (d_abs == '0) ? SC_NEXT : SC_MUL_P;
            end
            SC_MUL_P: begin
                if (mul_stat.done) n_state = SC_MUL_D2;
            end
            SC_MUL_D2: begin
                if (mul_stat.done) n_state = r_have ? SC_MUL_L : SC_NEXT;
            end
            SC_MUL_L: begin
                if (mul_stat.done) n_state = SC_MUL_R;
            end
            SC_MUL_R: begin
                if (mul_stat.done) n_state = SC_NEXT;
            end
            SC_NEXT: n_state = (r_bin == TOP_BIN) ? SC_DONE : SC_READ;
            SC_DONE: n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    // Outputs: operand select for the shared multiplier, histogram request, status
    always_comb begin
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        o_mem.rd   = 1'b0;
        o_mem.addr = r_bin;
        o_stat.done     = 1'b0;
        o_stat.thr      = r_thr;
        o_stat.last_bin = r_bin;
        unique case (r_state)
            SC_READ: o_mem.rd = 1'b1;
            SC_MUL_A: begin
                mul_start  = !mul_stat.busy;
                mul_mcand  = MC_W'(r_sb);
                mul_mplier = MQ_W'(i_total);
            end
            SC_MUL_B: begin
                mul_start  = !mul_stat.busy;
                mul_mcand  = MC_W'(i_sum);
                mul_mplier = MQ_W'(r_nb);
            end
            SC_MUL_P: begin
                mul_start  = !mul_stat.busy;
                mul_mcand  = MC_W'(i_total - r_nb);
                mul_mplier = MQ_W'(r_nb);
            end
            SC_MUL_D2: begin
                mul_start  = !mul_stat.busy;
                mul_mcand  = MC_W'(r_d);
                mul_mplier = MQ_W'(r_d);
            end
            SC_MUL_L: begin
                mul_start  = !mul_stat.busy;
                mul_mcand  = MC_W'(r_d2);
                mul_mplier = MQ_W'(r_best_p);
            end
            SC_MUL_R: begin
                mul_start  = !mul_stat.busy;
                mul_mcand  = MC_W'(r_best_d2);
                mul_mplier = MQ_W'(r_p);
            end
            SC_DONE: o_stat.done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Candidate datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    r_bin  <= '0;
                    r_nb   <= '0;
                    r_sb   <= '0;
                    r_have <= 1'b0;
                    r_thr  <= '0;
                end
            end
            SC_ACC: begin
                r_nb <= nb_new;
                r_sb <= sb_new;
            end
            SC_MUL_A: begin
                if (mul_stat.done) r_a <= mul_prod[A_W-1:0];
            end
            SC_MUL_B: begin
                if (mul_stat.done) r_d <= d_abs;
            end
            SC_MUL_P: begin
                if (mul_stat.done) r_p <= mul_prod[P_W-1:0];
            end
            SC_MUL_D2: begin
                if (mul_stat.done) begin
                    r_d2 <= mul_prod[D2_W-1:0];
                    // first candidate with nonzero variance
                    if (!r_have) begin
                        r_have    <= 1'b1;
                        r_best_d2 <= mul_prod[D2_W-1:0];
                        r_best_p  <= r_p;
                        r_thr     <= r_bin;
                    end
                end
            end
            SC_MUL_L: begin
                if (mul_stat.done) r_lhs <= mul_prod;
            end
            SC_MUL_R: begin
                // strictly larger variance wins; ties keep the earlier bin
                if (mul_stat.done && (r_lhs > mul_prod)) begin
                    r_best_d2 <= r_d2;
                    r_best_p  <= r_p;
                    r_thr     <= r_bin;
                end
            end
            SC_NEXT: begin
                if (r_bin != TOP_BIN) r_bin <= r_bin + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[src/otsu_threshold_finder.sv]
// Pixel request: TS_IDLE then TS_UPD when binned, TS_IDLE alone once the count is
// saturated. After the marked pixel, a skipped bin steps through SC_READ, SC_ACC and
// SC_NEXT; a candidate bin also runs up to six shift-add multiplies in one shared
// unit, one multiplier bit per cycle. Bins left unread after an early stop are zeroed
// at one bin per cycle after the result. Reset (synchronous, active low) starts a
// clear of all 256 bins, taking no pixel meanwhile; channel_select resets to 0.
`include "otsu_threshold_finder_defines.svh"

module otsu_threshold_finder
    import otsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // chan0_value, chan1_value, chan2_value
    input  logic               s_axis_tlast,   // last_sample
    // threshold stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // threshold
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_top_state r_state, n_state;

    logic [CHAN_W-1:0] r_chan_sel;
    logic [BIN_W-1:0]  r_clr_addr;
    logic [CNT_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_sum;
    logic [BIN_W-1:0]  r_bin;
    logic              r_last;
    logic [BIN_W-1:0]  r_thr;
    logic [BIN_W-1:0]  r_end;
    logic              r_out_valid;
    logic [BIN_W-1:0]  r_out_thr;

    logic              in_acc;
    logic              sat;
    logic              cfg_wr;
    logic [PIX_W-1:0]  pix_val;

    logic              mem_rd_en;
    logic [BIN_W-1:0]  mem_rd_addr;
    logic              mem_wr_en;
    logic [BIN_W-1:0]  mem_wr_addr;
    logic [CNT_W-1:0]  mem_wr_data;
    logic [CNT_W-1:0]  mem_rd_data;

    logic              scan_start;
    t_scan_mem         scan_mem;
    t_scan_stat        scan_stat;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign sat    = (r_total >= MAX_CNT);

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[REG_IDX_BIT] == REG_CHAN_SEL);
    assign prdata = (paddr[REG_IDX_BIT] == REG_CHAN_SEL) ? PDATA_W'(r_chan_sel) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_sel <= CHAN_SEL_0;
        end else if (cfg_wr) begin
            r_chan_sel <= pwdata[CHAN_W-1:0];
        end
    end

    // Channel select; the unused code picks channel 2
    always_comb begin
        unique case (r_chan_sel)
            CHAN_SEL_0: pix_val = s_axis_tdata[7:0];
            CHAN_SEL_1: pix_val = s_axis_tdata[15:8];
            default:    pix_val = s_axis_tdata[23:16];
        endcase
    end

    otsu_hist u_hist (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    otsu_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_total   (r_total),
        .i_sum     (r_sum),
        .i_rd_data (mem_rd_data),
        .o_mem     (scan_mem),
        .o_stat    (scan_stat)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_CLEAR: begin
                if (r_clr_addr == TOP_BIN) n_state = TS_IDLE;
            end
            TS_IDLE: begin
                if (in_acc) begin
                    if (!sat) begin
                        n_state = TS_UPD;
                    end else if (s_axis_tlast) begin
                        n_state = TS_SCAN;
                    end
                end
            end
            TS_UPD: n_state = r_last ? TS_SCAN : TS_IDLE;
            TS_SCAN: begin
                if (scan_stat.done) n_state = TS_EMIT;
            end
            TS_EMIT: begin
                if (!r_out_valid) n_state = (r_end == TOP_BIN) ? TS_IDLE : TS_CLEAR;
            end
            default: n_state = TS_IDLE;
        endcase
    end

    // Outputs: handshake and histogram port arbitration
    always_comb begin
        s_axis_tready = 1'b0;
        scan_start    = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = pix_val;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_clr_addr;
        mem_wr_data   = '0;
        unique case (r_state)
            TS_CLEAR: mem_wr_en = 1'b1;
            TS_IDLE: begin
                s_axis_tready = 1'b1;
                mem_rd_en     = in_acc && !sat;
                scan_start    = in_acc && sat && s_axis_tlast;
            end
            TS_UPD: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_bin;
                mem_wr_data = mem_rd_data + 1'b1;
                scan_start  = r_last;
            end
            TS_SCAN: begin
                // each scanned bin is zeroed as it is read
                mem_rd_en   = scan_mem.rd;
                mem_rd_addr = scan_mem.addr;
                mem_wr_en   = scan_mem.rd;
                mem_wr_addr = scan_mem.addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clear pointer, run totals, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == TS_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == TS_IDLE) && in_acc && !sat) begin
                r_total <= r_total + 1'b1;
                r_sum   <= r_sum + SUM_W'(pix_val);
            end
            if ((r_state == TS_EMIT) && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_total     <= '0;
                r_sum       <= '0;
                r_clr_addr  <= r_end + 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and scan payload
    always_ff @(posedge i_clk) begin
        if ((r_state == TS_IDLE) && in_acc) begin
            r_bin  <= pix_val;
            r_last <= s_axis_tlast;
        end
        if (scan_stat.done) begin
            r_thr <= scan_stat.thr;
            r_end <= scan_stat.last_bin;
        end
        if ((r_state == TS_EMIT) && !r_out_valid) begin
            r_out_thr <= r_thr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_thr;

    // Checks
    `OTSU_ASSERT_IMP(a_scan_done_in_scan, i_clk, i_rst_n, scan_stat.done, r_state == TS_SCAN)
    `OTSU_ASSERT_NEXT(a_sat_holds, i_clk, i_rst_n, in_acc && (r_total == MAX_CNT), r_total == MAX_CNT)
    `OTSU_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, (r_state == TS_EMIT) && !r_out_valid, m_axis_tvalid && (r_total == '0) && (r_sum == '0))

endmodule

[tb/otsu_threshold_finder_tb.sv]
`timescale 1ns / 100ps

module otsu_threshold_finder_tb;
    import otsu_pkg::*;

    // Selector codes the package leaves unnamed
    localparam logic [CHAN_W-1:0] CHAN_SEL_2     = 2'd2;
    localparam logic [CHAN_W-1:0] CHAN_SEL_SPARE = 2'd3;

    // Idle time after the last threshold: covers zeroing of bins left after an early stop
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_REQUESTS = 175;
    localparam int PRINT_CAP      = 50;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata  = '0;   // chan0_value, chan1_value, chan2_value
    logic               s_axis_tlast  = 1'b0; // last_sample
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;         // threshold
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    otsu_threshold_finder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Histogram mirror and pending thresholds
    logic [63:0]       hist_bins [NUM_BINS];
    logic [63:0]       run_count;
    logic [63:0]       run_sum;
    logic [CHAN_W-1:0] chan_sel;
    logic [7:0]        threshold_q [$];

    int  mismatch_count     = 0;
    int  pixels_sent        = 0;
    int  thresholds_checked = 0;
    bit  gaps_on            = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short idles, a few long ones
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] ERROR %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic void clear_histogram();
        foreach (hist_bins[b])
            hist_bins[b] = '0;
        run_count = '0;
        run_sum   = '0;
    endfunction

    // Scan thresholds upward; keep the first strictly largest (T*sB - nB*S)^2 / (nB*nF)
    function automatic logic [7:0] otsu_pick_threshold();
        logic [63:0]  n_bg, s_bg, n_fg, a_term, b_term, diff, prod, best_diff, best_prod;
        logic [191:0] lhs, rhs;
        logic         found;
        logic [7:0]   thr;
        int           bin;
        n_bg      = '0;
        s_bg      = '0;
        best_diff = '0;
        best_prod = '0;
        found     = 1'b0;
        thr       = '0;
        for (bin = 0; bin < NUM_BINS; bin++) begin
            n_bg += hist_bins[bin];
            if (n_bg == 0)
                continue;
            if (n_bg >= run_count)
                break;
            n_fg   = run_count - n_bg;
            s_bg  += 64'(bin) * hist_bins[bin];
            a_term = run_count * s_bg;
            b_term = n_bg * run_sum;
            diff   = (a_term >= b_term) ? (a_term - b_term) : (b_term - a_term);
            if (diff == 0)
                continue;
            prod = n_bg * n_fg;
            if (!found) begin
                found     = 1'b1;
                best_diff = diff;
                best_prod = prod;
                thr       = 8'(bin);
            end else begin
                lhs = 192'(diff) * 192'(diff) * 192'(best_prod);
                rhs = 192'(best_diff) * 192'(best_diff) * 192'(prod);
                if (lhs > rhs) begin
                    best_diff = diff;
                    best_prod = prod;
                    thr       = 8'(bin);
                end
            end
        end
        return thr;
    endfunction

    // Bin one accepted pixel; a marked pixel closes the run
    function automatic void absorb_pixel(input logic [23:0] pix, input logic last);
        logic [7:0] v;
        case (chan_sel)
            CHAN_SEL_0: v = pix[7:0];
            CHAN_SEL_1: v = pix[15:8];
            default:    v = pix[23:16];
        endcase
        if (run_count < 64'(MAX_SAMPLES)) begin
            hist_bins[v] += 1;
            run_count    += 1;
            run_sum      += 64'(v);
        end
        if (last) begin
            threshold_q.push_back(otsu_pick_threshold());
            clear_histogram();
        end
    endfunction

    // Pixel with the selected channel set to v, the other channels random
    function automatic logic [23:0] make_pixel(input logic [7:0] v);
        logic [23:0] p;
        p = 24'($urandom);
        case (chan_sel)
            CHAN_SEL_0: p[7:0]   = v;
            CHAN_SEL_1: p[15:8]  = v;
            default:    p[23:16] = v;
        endcase
        return p;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with tvalid held
    task automatic send_pixel(input logic [23:0] pix, input logic last);
        int gap;
        gap = gaps_on ? pick_idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_pixel(pix, last);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (threshold_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle_block();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write channel_select (random upper bits), then read it back
    task automatic write_channel_select(input logic [CHAN_W-1:0] sel);
        logic [PDATA_W-1:0] wdata;
        wdata              = PDATA_W'($urandom);
        wdata[CHAN_W-1:0]  = sel;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_CHAN_SEL) << REG_IDX_BIT;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        chan_sel = sel;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CHAN_W-1:0] !== sel)
            report_mismatch("channel_select readback", 32'(prdata[CHAN_W-1:0]), 32'(sel));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: ready bursts of random length with random stalls between
    initial begin : result_sink
        int hold;
        @(negedge i_clk);
        forever begin
            hold = ($urandom_range(0, 99) < 20) ? $urandom_range(200, 2000)
                                                : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (hold) @(negedge i_clk);
            hold = pick_idle_len();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
        end
    end

    // Compare each accepted threshold with the oldest pending one
    always @(posedge i_clk) begin : threshold_check
        logic [7:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (threshold_q.size() == 0) begin
                report_mismatch("threshold with no run pending", 32'(m_axis_tdata), 0);
            end else begin
                want = threshold_q.pop_front();
                thresholds_checked++;
                if (m_axis_tdata !== want)
                    report_mismatch("threshold", 32'(m_axis_tdata), 32'(want));
            end
        end
    end

    // Reset-value selector: single pixel, single value, extremes, empty bins and ties
    task automatic test_directed_runs();
        send_pixel(make_pixel(8'd0), 1'b1);
        send_pixel(make_pixel(8'd255), 1'b0);
        send_pixel(make_pixel(8'd255), 1'b1);
        send_pixel(make_pixel(8'd0), 1'b0);
        send_pixel(make_pixel(8'd255), 1'b1);
        // empty background below 50, equal variance across the empty bins 51..59
        send_pixel(make_pixel(8'd50), 1'b0);
        send_pixel(make_pixel(8'd60), 1'b0);
        send_pixel(make_pixel(8'd60), 1'b0);
        send_pixel(make_pixel(8'd200), 1'b1);
        send_pixel(make_pixel(8'd100), 1'b0);
        send_pixel(make_pixel(8'd101), 1'b0);
        send_pixel(make_pixel(8'd102), 1'b0);
        send_pixel(make_pixel(8'd180), 1'b0);
        send_pixel(make_pixel(8'd181), 1'b1);
    endtask

    // Selector codes 1, 2 and the unused code 3; code 3 picks channel 2 like code 2
    task automatic test_channel_routing();
        logic [CHAN_W-1:0] sels [3];
        int s;
        sels[0] = CHAN_SEL_1;
        sels[1] = CHAN_SEL_2;
        sels[2] = CHAN_SEL_SPARE;
        for (s = 0; s < 3; s++) begin
            settle_block();
            write_channel_select(sels[s]);
            send_pixel(make_pixel(8'd20), 1'b0);
            send_pixel(make_pixel(8'd90), 1'b0);
            send_pixel(make_pixel(8'd240), 1'b1);
        end
    endtask

    // Runs of random length, mostly over a narrow value window, a few full range
    task automatic test_random_runs();
        logic [CHAN_W-1:0] phase_sel [4];
        int         phase, phase_items, run_idx, len, base, span, k, tmp;
        logic       wide;
        logic [7:0] v;
        phase_sel[0] = CHAN_SEL_SPARE;
        phase_sel[1] = CHAN_SEL_1;
        phase_sel[2] = CHAN_SEL_0;
        phase_sel[3] = CHAN_SEL_2;
        for (phase = 0; phase < 4; phase++) begin
            settle_block();
            write_channel_select(phase_sel[phase]);
            phase_items = 0;
            run_idx     = 0;
            while (phase_items < PHASE_REQUESTS) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                wide    = ((run_idx % 9) == 3);
                base    = $urandom_range(0, 255);
                span    = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7)
                                                       : $urandom_range(8, 20);
                if (wide)
                    len = $urandom_range(20, 48);
                else if ($urandom_range(0, 99) < 15)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(4, 24);
                for (k = 0; k < len; k++) begin
                    if (wide) begin
                        v = 8'($urandom_range(0, 255));
                    end else begin
                        tmp = base + $urandom_range(0, span);
                        v   = (tmp > 255) ? 8'hFF : 8'(tmp);
                    end
                    send_pixel(make_pixel(v), k == len - 1);
                end
                phase_items += len;
                run_idx++;
                // stop feeding once mid-phase until every threshold is back
                if (phase == 1 && run_idx == 5)
                    hold_until_drained();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        clear_histogram();
        chan_sel = CHAN_SEL_0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_runs();
        test_channel_routing();
        test_random_runs();
        settle_block();

        $display("Sent %0d pixels: directed runs, all four selector codes and random runs",
                 pixels_sent);
        $display("with stalls on both sides; %0d thresholds compared, %0d mismatches.",
                 thresholds_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #250_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
